FILE: design/npa_pkg.sv
`default_nettype none

package npa_pkg;

    localparam int POOL_INDEX_BITS = 12;
    localparam int MAX_BATCH       = 16;

    localparam int COUNT_W   = POOL_INDEX_BITS + 1;
    localparam int BATCH_W   = $clog2(MAX_BATCH + 1);
    localparam int BUF_IDX_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [COUNT_W-1:0] POOL_SIZE = COUNT_W'(1) << POOL_INDEX_BITS;

    // Packed stream widths.
    localparam int S_TDATA_W = ((BATCH_W + POOL_INDEX_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((POOL_INDEX_BITS + 1 + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_NODES = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

endpackage

`default_nettype wire

FILE: design/node_pool_allocator_top.sv
`default_nettype none

// Node pool allocator. Requests arrive on the s_ stream (tuser = function,
// tdata = batch count and node index); results leave on the m_ stream, one
// transfer per granted node, with tlast on the final result of a request.
// An allocate pops indices off a free stack kept in a 2^12 x 12 synchronous
// RAM, then bumps a high-water count up to min(max_nodes, pool size). When
// the pool cannot cover the whole batch, the stack is restored with the
// popped nodes in grant order plus the freshly bumped ones, and a single
// out-of-nodes result is sent. max_nodes is written through cfg_valid/cfg_data;
// the user must write it only while the block is idle, which the block itself
// does not enforce. max_nodes resets to 4096. s_tready is high only while no
// request is in progress. Free and check decode the request and send one result.
// An allocate decodes, then per popped node issues one RAM read and then sends
// the result, then sends one result per bumped node. A failed allocate reads and
// captures each stacked node, writes them back reversed, bumps the fresh nodes
// and sends the result. All work is serialized on the single RAM port.
// A one-deep output register holds a result while m_tready is low; the
// sequencer waits until that slot frees. Reset empties the stack and the
// high-water count; the RAM contents are not cleared.
module node_pool_allocator_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [4:0] batch_count, [16:5] node_index, rest zero
    input  wire logic [npa_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] func
    input  wire logic [npa_pkg::FUNC_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [11:0] granted_index, [12] is_valid, rest zero
    output logic [npa_pkg::M_TDATA_W-1:0]          m_tdata,
    // [1:0] status
    output logic [npa_pkg::STATUS_W-1:0]           m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [npa_pkg::COUNT_W-1:0]       cfg_data
);

    localparam int IW = npa_pkg::POOL_INDEX_BITS;
    localparam int CW = npa_pkg::COUNT_W;
    localparam int BW = npa_pkg::BATCH_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_POP_RD    = 4'd2;
    localparam logic [3:0] S_POP_EMIT  = 4'd3;
    localparam logic [3:0] S_BUMP      = 4'd4;
    localparam logic [3:0] S_REV_RD    = 4'd5;
    localparam logic [3:0] S_REV_CAP   = 4'd6;
    localparam logic [3:0] S_REV_WR    = 4'd7;
    localparam logic [3:0] S_FAIL_BUMP = 4'd8;
    localparam logic [3:0] S_FAIL_EMIT = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic [CW-1:0] hoc_reg, hoc_next;
    logic [CW-1:0] max_nodes_reg;
    logic [BW-1:0] rem_reg, rem_next;
    logic [BW-1:0] idx_reg, idx_next;

    logic [npa_pkg::FUNC_W-1:0] func_reg;
    logic [BW-1:0]              count_reg;
    logic [IW-1:0]              node_reg;

    logic [IW-1:0] stack_mem [npa_pkg::POOL_SIZE];
    logic [IW-1:0] rd_data_reg;
    logic [IW-1:0] taken_reg [npa_pkg::MAX_BATCH];

    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_wdata, mem_raddr;

    logic                         m_valid_reg;
    logic [IW-1:0]                out_index_reg;
    logic [npa_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_isvalid_reg;
    logic                         out_last_reg;

    logic                         emit;
    logic [IW-1:0]                emit_index;
    logic [npa_pkg::STATUS_W-1:0] emit_status;
    logic                         emit_isvalid;
    logic                         emit_last;
    logic                         can_emit;

    logic [CW-1:0] limit;
    logic [CW-1:0] headroom;
    logic [BW-1:0] want;
    logic          pool_short;
    logic          s_xfer;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign can_emit  = !m_valid_reg || m_tready;

    assign limit    = (max_nodes_reg > npa_pkg::POOL_SIZE) ? npa_pkg::POOL_SIZE : max_nodes_reg;
    assign headroom = (limit > hoc_reg) ? (limit - hoc_reg) : '0;
    assign want     = (count_reg > BW'(npa_pkg::MAX_BATCH)) ? BW'(npa_pkg::MAX_BATCH)
                                                             : count_reg;
    assign pool_short = ({1'b0, depth_reg} + {1'b0, headroom}) < (CW + 1)'(want);

    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        hoc_next     = hoc_reg;
        rem_next     = rem_reg;
        idx_next     = idx_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = depth_reg[IW-1:0];
        mem_wdata    = hoc_reg[IW-1:0];
        mem_raddr    = IW'(depth_reg - CW'(1));
        emit         = 1'b0;
        emit_index   = '0;
        emit_status  = npa_pkg::STATUS_OK;
        emit_isvalid = 1'b0;
        emit_last    = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (func_reg == npa_pkg::FUNC_CHECK) begin
                    if (can_emit) begin
                        emit         = 1'b1;
                        emit_isvalid = (CW'(node_reg) < hoc_reg);
                        state_next   = S_IDLE;
                    end
                end else if (func_reg == npa_pkg::FUNC_FREE) begin
                    if (can_emit) begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (CW'(node_reg) >= hoc_reg || depth_reg >= hoc_reg) begin
                            emit_status = npa_pkg::STATUS_BAD_FREE;
                        end else begin
                            mem_we     = 1'b1;
                            mem_wdata  = node_reg;
                            depth_next = depth_reg + CW'(1);
                        end
                    end
                end else if (func_reg == npa_pkg::FUNC_ALLOC) begin
                    priority if (want == '0) begin
                        if (can_emit) begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end else if (pool_short) begin
                        // Every stacked node is taken, so the whole stack is
                        // reversed in place before the bumped nodes go on top.
                        idx_next   = '0;
                        state_next = (depth_reg == '0) ? S_FAIL_BUMP : S_REV_RD;
                    end else begin
                        rem_next   = want;
                        state_next = (depth_reg == '0) ? S_BUMP : S_POP_RD;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_POP_RD: begin
                mem_re     = 1'b1;
                depth_next = depth_reg - CW'(1);
                rem_next   = rem_reg - BW'(1);
                state_next = S_POP_EMIT;
            end
            S_POP_EMIT: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    emit_index = rd_data_reg;
                    emit_last  = (rem_reg == '0);
                    priority if (rem_reg == '0) begin
                        state_next = S_IDLE;
                    end else if (depth_reg == '0) begin
                        state_next = S_BUMP;
                    end else begin
                        state_next = S_POP_RD;
                    end
                end
            end
            S_BUMP: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    emit_index = hoc_reg[IW-1:0];
                    emit_last  = (rem_reg == BW'(1));
                    hoc_next   = hoc_reg + CW'(1);
                    rem_next   = rem_reg - BW'(1);
                    if (rem_reg == BW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REV_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = IW'(depth_reg - CW'(1) - CW'(idx_reg));
                state_next = S_REV_CAP;
            end
            S_REV_CAP: begin
                idx_next = idx_reg + BW'(1);
                if (CW'(idx_next) == depth_reg) begin
                    idx_next   = '0;
                    state_next = S_REV_WR;
                end else begin
                    state_next = S_REV_RD;
                end
            end
            S_REV_WR: begin
                mem_we    = 1'b1;
                mem_waddr = IW'(idx_reg);
                mem_wdata = taken_reg[idx_reg[npa_pkg::BUF_IDX_W-1:0]];
                idx_next  = idx_reg + BW'(1);
                if (CW'(idx_next) == depth_reg) begin
                    state_next = S_FAIL_BUMP;
                end
            end
            S_FAIL_BUMP: begin
                if (hoc_reg >= limit) begin
                    state_next = S_FAIL_EMIT;
                end else begin
                    mem_we     = 1'b1;
                    depth_next = depth_reg + CW'(1);
                    hoc_next   = hoc_reg + CW'(1);
                end
            end
            S_FAIL_EMIT: begin
                if (can_emit) begin
                    emit        = 1'b1;
                    emit_status = npa_pkg::STATUS_NO_NODES;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            hoc_reg       <= '0;
            rem_reg       <= '0;
            idx_reg       <= '0;
            max_nodes_reg <= npa_pkg::POOL_SIZE;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            hoc_reg   <= hoc_next;
            rem_reg   <= rem_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready) begin
                max_nodes_reg <= cfg_data;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            func_reg  <= s_tuser;
            count_reg <= s_tdata[BW-1:0];
            node_reg  <= s_tdata[BW+IW-1:BW];
        end
        if (emit) begin
            out_index_reg   <= emit_index;
            out_status_reg  <= emit_status;
            out_isvalid_reg <= emit_isvalid;
            out_last_reg    <= emit_last;
        end
        if (state_reg == S_REV_CAP) begin
            taken_reg[idx_reg[npa_pkg::BUF_IDX_W-1:0]] <= rd_data_reg;
        end
    end

    // Reads and writes never share a cycle; a read issued after a write to
    // the same entry sees the new value because the sequencer separates them.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = npa_pkg::M_TDATA_W'({out_isvalid_reg, out_index_reg});
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_depth_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= hoc_reg)
        else $error("free stack holds more nodes than were ever handed out");

    a_hoc_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        hoc_reg >= $past(hoc_reg))
        else $error("high-water count decreased");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POP_RD |-> depth_reg != '0)
        else $error("pop from an empty free stack");

    a_fail_exhausted: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_status == npa_pkg::STATUS_NO_NODES) |-> hoc_reg >= limit)
        else $error("out-of-nodes reported while bump headroom remains");

    a_no_mem_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("RAM read and write issued in the same cycle");
`endif

endmodule

`default_nettype wire

FILE: tb/node_pool_allocator_top_tb.sv
`timescale 1ns / 100ps

module node_pool_allocator_top_tb;

    typedef logic [npa_pkg::POOL_INDEX_BITS-1:0] index_t;
    typedef logic [npa_pkg::BATCH_W-1:0]         count_t;
    typedef logic [npa_pkg::COUNT_W-1:0]         level_t;
    typedef logic [npa_pkg::FUNC_W-1:0]          func_t;
    typedef logic [npa_pkg::STATUS_W-1:0]        status_t;

    localparam func_t FUNC_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int IB           = npa_pkg::POOL_INDEX_BITS;
    localparam int TW           = npa_pkg::M_TDATA_W;

    typedef struct packed {
        index_t  index;
        status_t status;
        logic    valid;
        logic    last;
    } pool_resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [npa_pkg::S_TDATA_W-1:0] s_tdata = '0;
    func_t s_tuser = npa_pkg::FUNC_CHECK;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TW-1:0] m_tdata;
    status_t m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    level_t cfg_data = '0;

    // Shadow copy of the allocator state.
    index_t shadow_stack [1 << npa_pkg::POOL_INDEX_BITS];
    level_t shadow_depth = '0;
    level_t shadow_high_water = '0;
    level_t shadow_max = npa_pkg::POOL_SIZE;

    pool_resp_t expected_responses [$];
    index_t held_nodes [$];

    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;
    int stall_left = 0;
    int failures = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int configs_written = 0;
    int grants_seen = 0;
    int dry_allocs = 0;
    int rejected_frees = 0;

    node_pool_allocator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic log_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    function automatic pool_resp_t make_resp(input index_t index, input status_t status,
                                             input logic valid, input logic last);
        pool_resp_t r;
        r.index  = index;
        r.status = status;
        r.valid  = valid;
        r.last   = last;
        return r;
    endfunction

    function automatic void push_shadow(input index_t node);
        if (shadow_depth < npa_pkg::POOL_SIZE) begin
            shadow_stack[shadow_depth[IB-1:0]] = node;
            shadow_depth++;
        end
    endfunction

    // Works out the results of one accepted request and advances the shadow state.
    task automatic predict_pool_response(input func_t func, input count_t count,
                                         input index_t node);
        index_t taken [npa_pkg::MAX_BATCH];
        level_t limit;
        int want;
        int n;
        bit dry;
        case (func)
            npa_pkg::FUNC_ALLOC: begin
                limit = (shadow_max < npa_pkg::POOL_SIZE) ? shadow_max : npa_pkg::POOL_SIZE;
                want = (count > npa_pkg::MAX_BATCH) ? npa_pkg::MAX_BATCH : int'(count);
                n = 0;
                dry = 1'b0;
                if (want == 0) begin
                    expected_responses.push_back(
                        make_resp('0, npa_pkg::STATUS_OK, 1'b0, 1'b1));
                end else begin
                    while (shadow_depth > 0 && n < want) begin
                        shadow_depth--;
                        taken[n] = shadow_stack[shadow_depth[IB-1:0]];
                        n++;
                    end
                    while (n < want && !dry) begin
                        if (shadow_high_water >= limit) begin
                            dry = 1'b1;
                        end else begin
                            taken[n] = shadow_high_water[IB-1:0];
                            shadow_high_water++;
                            n++;
                        end
                    end
                    if (dry) begin
                        // Everything taken goes back in grant order, bumped nodes too.
                        for (int i = 0; i < n; i++) begin
                            push_shadow(taken[i]);
                        end
                        expected_responses.push_back(
                            make_resp('0, npa_pkg::STATUS_NO_NODES, 1'b0, 1'b1));
                        dry_allocs++;
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            expected_responses.push_back(
                                make_resp(taken[i], npa_pkg::STATUS_OK, 1'b0, i == n - 1));
                            held_nodes.push_back(taken[i]);
                        end
                        grants_seen += n;
                    end
                end
            end
            npa_pkg::FUNC_FREE: begin
                if (node >= shadow_high_water || shadow_depth >= shadow_high_water) begin
                    expected_responses.push_back(
                        make_resp('0, npa_pkg::STATUS_BAD_FREE, 1'b0, 1'b1));
                    rejected_frees++;
                end else begin
                    push_shadow(node);
                    expected_responses.push_back(
                        make_resp('0, npa_pkg::STATUS_OK, 1'b0, 1'b1));
                end
            end
            npa_pkg::FUNC_CHECK: begin
                expected_responses.push_back(
                    make_resp('0, npa_pkg::STATUS_OK, node < shadow_high_water, 1'b1));
            end
            default: begin
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_steady || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Drives one request and holds it until the transfer completes.
    task automatic send_request(input func_t func, input count_t count, input index_t node);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(npa_pkg::S_TDATA_W - npa_pkg::BATCH_W - IB){1'b0}}, node, count};
        do @(posedge aclk); while (!s_tready);
        predict_pool_response(func, count, node);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge aclk);
        // A request with no result may still be in flight.
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_nodes(input level_t value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_max = value;
        configs_written++;
    endtask

    // Result sink with random backpressure.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!sink_steady && $urandom_range(0, 99) < 20) begin
            m_tready <= 1'b0;
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                    : $urandom_range(9, 39);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pool_resp_t want_r;
        string exp_s;
        string got_s;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_responses.size() == 0) begin
                log_failure($sformatf("unexpected result idx=%0d status=%0d valid=%0b last=%0b",
                                      m_tdata[IB-1:0], m_tuser, m_tdata[IB], m_tlast));
            end else begin
                want_r = expected_responses.pop_front();
                if (m_tdata[IB-1:0] !== want_r.index ||
                    m_tuser !== want_r.status ||
                    m_tdata[IB] !== want_r.valid ||
                    m_tlast !== want_r.last ||
                    m_tdata[TW-1:IB+1] !== '0) begin
                    exp_s = $sformatf("expected idx=%0d status=%0d valid=%0b last=%0b, ",
                                      want_r.index, want_r.status, want_r.valid,
                                      want_r.last);
                    got_s = $sformatf("got idx=%0d status=%0d valid=%0b last=%0b pad=%0h",
                                      m_tdata[IB-1:0], m_tuser, m_tdata[IB], m_tlast,
                                      m_tdata[TW-1:IB+1]);
                    log_failure({exp_s, got_s});
                end
            end
        end
    end

    // Starting from an empty pool: empty, oversized and plain allocates, checks,
    // both kinds of rejected free, a double free and an unused function code.
    task automatic test_basic_requests();
        send_request(npa_pkg::FUNC_CHECK, 5'd0, 12'd0);
        send_request(npa_pkg::FUNC_FREE, 5'd0, 12'd0);
        send_request(npa_pkg::FUNC_ALLOC, 5'd0, 12'd0);
        send_request(npa_pkg::FUNC_ALLOC, 5'd1, 12'd0);
        send_request(npa_pkg::FUNC_FREE, 5'd0, 12'd0);
        send_request(npa_pkg::FUNC_FREE, 5'd0, 12'd0);
        send_request(npa_pkg::FUNC_ALLOC, 5'd2, 12'd0);
        send_request(npa_pkg::FUNC_FREE, 5'd0, 12'd1);
        send_request(npa_pkg::FUNC_FREE, 5'd0, 12'd1);
        send_request(npa_pkg::FUNC_FREE, 5'd0, 12'd0);
        send_request(npa_pkg::FUNC_ALLOC, 5'd16, 12'd0);
        send_request(npa_pkg::FUNC_ALLOC, 5'd31, 12'd0);
        send_request(npa_pkg::FUNC_CHECK, 5'd31, 12'd31);
        send_request(npa_pkg::FUNC_CHECK, 5'd0, 12'd32);
        send_request(npa_pkg::FUNC_CHECK, 5'd0, 12'd4095);
        send_request(npa_pkg::FUNC_FREE, 5'd0, 12'd4095);
        send_request(FUNC_UNUSED, 5'd31, 12'd4095);
    endtask

    // Pool exhaustion with popped and bumped nodes returned to the stack.
    task automatic test_pool_exhaustion();
        write_max_nodes(13'd1);
        send_request(npa_pkg::FUNC_ALLOC, 5'd2, 12'd0);
        send_request(npa_pkg::FUNC_FREE, 5'd0, 12'd3);
        send_request(npa_pkg::FUNC_FREE, 5'd0, 12'd7);
        send_request(npa_pkg::FUNC_ALLOC, 5'd4, 12'd0);
        send_request(npa_pkg::FUNC_ALLOC, 5'd2, 12'd0);
        write_max_nodes(shadow_high_water + 13'd8);
        send_request(npa_pkg::FUNC_ALLOC, 5'd16, 12'd0);
        send_request(npa_pkg::FUNC_ALLOC, 5'd8, 12'd0);
    endtask

    task automatic test_random_traffic(input int n_items, input level_t limit);
        int r;
        int sent;
        int hi;
        int pos;
        count_t count;
        index_t node;
        write_max_nodes(limit);
        sent = 0;
        while (sent < n_items) begin
            src_steady  = (sent % 40) >= 30;
            sink_steady = (sent % 40) >= 25 && (sent % 40) < 32;
            r = $urandom_range(0, 99);
            hi = int'(shadow_high_water) + 2;
            if (hi > 4095) hi = 4095;
            if (r < 45) begin
                r = $urandom_range(0, 99);
                if (r < 85) count = count_t'($urandom_range(1, npa_pkg::MAX_BATCH));
                else if (r < 92) count = 5'd0;
                else count = count_t'($urandom_range(npa_pkg::MAX_BATCH + 1, 31));
                send_request(npa_pkg::FUNC_ALLOC, count, index_t'($urandom_range(0, 4095)));
                sent++;
            end else if (r < 80) begin
                if (held_nodes.size() != 0 && $urandom_range(0, 9) < 8) begin
                    pos = $urandom_range(0, held_nodes.size() - 1);
                    node = held_nodes[pos];
                    held_nodes.delete(pos);
                end else if ($urandom_range(0, 1) == 0) begin
                    node = index_t'($urandom_range(0, hi));
                end else begin
                    node = index_t'($urandom_range(0, 4095));
                end
                send_request(npa_pkg::FUNC_FREE, count_t'($urandom_range(0, 31)), node);
                sent++;
            end else if (r < 95) begin
                node = ($urandom_range(0, 1) == 0) ? index_t'($urandom_range(0, hi))
                                                   : index_t'($urandom_range(0, 4095));
                send_request(npa_pkg::FUNC_CHECK, count_t'($urandom_range(0, 31)), node);
                sent++;
            end else begin
                send_request(FUNC_UNUSED, count_t'($urandom_range(0, 31)),
                             index_t'($urandom_range(0, 4095)));
            end
            if (sent % 60 == 59) begin
                wait_drained();
            end
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_requests();
        test_pool_exhaustion();
        test_random_traffic(45, shadow_high_water + 13'd50);
        test_random_traffic(45, 13'd1);
        test_random_traffic(45, npa_pkg::POOL_SIZE);
        test_random_traffic(45, shadow_high_water + 13'($urandom_range(0, 30)));
        test_random_traffic(45, 13'd4095);
        s_tvalid <= 1'b0;
        for (int w = 0; w < 200000 && expected_responses.size() != 0; w++) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_responses.size() != 0) begin
            log_failure($sformatf("%0d results never arrived", expected_responses.size()));
        end
        $display("Sent %0d requests, checked %0d result transfers, wrote max_nodes %0d times.",
                 requests_sent, results_seen, configs_written);
        $display("Saw %0d granted nodes, %0d exhausted allocates, %0d rejected frees.",
                 grants_seen, dry_allocs, rejected_frees);
        if (failures == 0) begin
            $display("node_pool_allocator_top verification clean");
        end else begin
            $display("%0d mismatches in total", failures);
            $display("node_pool_allocator_top verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding", expected_responses.size());
        $display("node_pool_allocator_top verification failed");
        $finish;
    end

endmodule
